### src/stmin_pkg.sv
`timescale 1ns / 1ps

package stmin_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int LEVELS_DEF = 11;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int LOG_W      = $clog2(CNT_W);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic load_we;
    logic cfg_we;
    logic build_init;
    logic build_rd;
    logic lvl_next;
    logic query_rd;
    logic out_ld;
    logic built;
  } stmin_cmd_t;

  typedef struct packed {
    logic index_ok;
    logic level_ok;
    logic last_j;
    logic out_free;
  } stmin_sts_t;

  function automatic logic [LOG_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) begin
        r = LOG_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### src/stmin_ram.sv
`timescale 1ns / 1ps

module stmin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output logic [WIDTH-1:0]         rd_data_a_o,
  output logic [WIDTH-1:0]         rd_data_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_a_o <= mem[rd_addr_a_i];
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule

### src/stmin_ctrl.sv
`timescale 1ns / 1ps

module stmin_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  input  logic [1:0]             cmd_i,
  input  logic                   cfg_valid_i,
  input  stmin_pkg::stmin_sts_t  sts_i,
  output stmin_pkg::stmin_cmd_t  cmd_o,
  output logic                   s_ready_o,
  output logic                   cfg_ready_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_BSTART = 5'b00010,
    S_BRUN   = 5'b00100,
    S_BDRAIN = 5'b01000,
    S_QCMP   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   built_q, built_d;
  logic   s_accept;
  logic   cfg_accept;

  assign s_ready_o   = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign s_accept    = s_valid_i && s_ready_o;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;

  always_comb begin
    state_d      = state_q;
    built_d      = built_q;
    cmd_o        = '0;
    cmd_o.built  = built_q;
    if (cfg_accept) begin
      cmd_o.cfg_we = 1'b1;
      built_d      = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          case (stmin_pkg::cmd_e'(cmd_i))
            stmin_pkg::CMD_LOAD: begin
              if (sts_i.index_ok) begin
                cmd_o.load_we = 1'b1;
                built_d       = 1'b0;
              end
            end
            stmin_pkg::CMD_BUILD: begin
              cmd_o.build_init = 1'b1;
              state_d          = S_BSTART;
            end
            stmin_pkg::CMD_QUERY: begin
              cmd_o.query_rd = 1'b1;
              state_d        = S_QCMP;
            end
            default: begin
            end
          endcase
        end
      end
      S_BSTART: begin
        if (sts_i.level_ok) begin
          state_d = S_BRUN;
        end else begin
          built_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_BRUN: begin
        cmd_o.build_rd = 1'b1;
        if (sts_i.last_j) begin
          state_d = S_BDRAIN;
        end
      end
      S_BDRAIN: begin
        cmd_o.lvl_next = 1'b1;
        state_d        = S_BSTART;
      end
      S_QCMP: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      built_q <= 1'b0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
    end
  end

endmodule

### src/stmin_dp.sv
`timescale 1ns / 1ps

module stmin_dp #(
  parameter int DEPTH  = stmin_pkg::DEPTH_DEF,
  parameter int LEVELS = stmin_pkg::LEVELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  stmin_pkg::stmin_cmd_t              cmd_i,
  output stmin_pkg::stmin_sts_t              sts_o,
  input  logic [stmin_pkg::IDX_W-1:0]        index_i,
  input  logic signed [stmin_pkg::DATA_W-1:0] value_i,
  input  logic [stmin_pkg::IDX_W-1:0]        left_i,
  input  logic [stmin_pkg::IDX_W-1:0]        right_i,
  input  logic [stmin_pkg::CNT_W-1:0]        cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [stmin_pkg::DATA_W-1:0] out_min_o,
  output logic                               out_err_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(LEVELS);
  localparam int LVW   = $clog2(LEVELS + 1);
  localparam int CQW   = ($clog2(DEPTH + 1) > stmin_pkg::CNT_W) ?
                         $clog2(DEPTH + 1) : stmin_pkg::CNT_W;
  localparam int SW    = ((LEVELS > CQW) ? LEVELS : CQW) + 2;
  localparam int RAM_D = LEVELS << AW;
  localparam int DW    = stmin_pkg::DATA_W;

  logic [LVW-1:0]       lvl_q;
  logic [AW-1:0]        j_q;
  logic [CQW-1:0]       count_q;
  logic                 wr_pend_q;
  logic [LW+AW-1:0]     wr_addr_q;
  logic                 err_q;
  logic                 out_valid_q;
  logic signed [DW-1:0] out_min_q;
  logic                 out_err_q;

  logic [SW-1:0]        count_x, span_x, half_x, j_x, jb_x, right_x, left_x, second_x;
  logic [SW-1:0]        index_x, cfg_x;
  logic [LW-1:0]        lvl_rd, lvl_wr, k_sel;
  logic [AW-1:0]        jb_addr, left_addr, second_addr, index_addr;
  logic [stmin_pkg::CNT_W-1:0] len;
  logic [stmin_pkg::LOG_W-1:0] k_raw;
  logic                 q_err;

  logic                 ram_we, ram_re;
  logic [LW+AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
  logic signed [DW-1:0] ram_wdata, rd_a, rd_b, rd_min;

  assign count_x  = SW'(count_q);
  assign span_x   = SW'(1) << lvl_q;
  assign half_x   = span_x >> 1;
  assign j_x      = SW'(j_q);
  assign jb_x     = j_x + half_x;
  assign jb_addr  = jb_x[AW-1:0];
  assign lvl_rd   = LW'(lvl_q - LVW'(1));
  assign lvl_wr   = LW'(lvl_q);

  assign index_x    = SW'(index_i);
  assign index_addr = index_x[AW-1:0];
  assign cfg_x      = SW'(cfg_data_i);

  assign right_x   = SW'(right_i);
  assign left_x    = SW'(left_i);
  assign left_addr = left_x[AW-1:0];
  assign len       = stmin_pkg::CNT_W'(right_i) - stmin_pkg::CNT_W'(left_i) +
                     stmin_pkg::CNT_W'(1);
  assign k_raw     = stmin_pkg::floor_log2(len);

  always_comb begin
    if (int'(k_raw) > LEVELS - 1) begin
      k_sel = LW'(LEVELS - 1);
    end else begin
      k_sel = LW'(k_raw);
    end
  end

  assign second_x    = right_x + SW'(1) - (SW'(1) << k_sel);
  assign second_addr = second_x[AW-1:0];

  assign q_err = !cmd_i.built || (left_i > right_i) || (right_x >= count_x) ||
                 (right_x >= SW'(DEPTH));

  assign sts_o.index_ok = (index_x < SW'(DEPTH));
  assign sts_o.level_ok = (int'(lvl_q) < LEVELS) && (span_x <= count_x);
  assign sts_o.last_j   = (j_x + SW'(1) + span_x) > count_x;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign rd_min = (rd_a < rd_b) ? rd_a : rd_b;

  always_comb begin
    if (cmd_i.load_we) begin
      ram_we    = 1'b1;
      ram_waddr = {LW'(0), index_addr};
      ram_wdata = value_i;
    end else begin
      ram_we    = wr_pend_q;
      ram_waddr = wr_addr_q;
      ram_wdata = rd_min;
    end
    ram_re = cmd_i.query_rd || cmd_i.build_rd;
    if (cmd_i.query_rd) begin
      ram_raddr_a = {k_sel, left_addr};
      ram_raddr_b = {k_sel, second_addr};
    end else begin
      ram_raddr_a = {lvl_rd, j_q};
      ram_raddr_b = {lvl_rd, jb_addr};
    end
  end

  stmin_ram #(
    .WIDTH (DW),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (ram_we),
    .wr_addr_i   (ram_waddr),
    .wr_data_i   (ram_wdata),
    .rd_en_i     (ram_re),
    .rd_addr_a_i (ram_raddr_a),
    .rd_addr_b_i (ram_raddr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q       <= LVW'(1);
      j_q         <= '0;
      count_q     <= CQW'(DEPTH);
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.build_rd;
      if (cmd_i.cfg_we) begin
        if (cfg_x > SW'(DEPTH)) begin
          count_q <= CQW'(DEPTH);
        end else begin
          count_q <= CQW'(cfg_data_i);
        end
      end
      if (cmd_i.build_init) begin
        lvl_q <= LVW'(1);
        j_q   <= '0;
      end else if (cmd_i.lvl_next) begin
        lvl_q <= lvl_q + LVW'(1);
        j_q   <= '0;
      end else if (cmd_i.build_rd) begin
        j_q <= j_q + AW'(1);
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_rd) begin
      wr_addr_q <= {lvl_wr, j_q};
    end
    if (cmd_i.query_rd) begin
      err_q <= q_err;
    end
    if (cmd_i.out_ld) begin
      out_err_q <= err_q;
      out_min_q <= err_q ? '0 : rd_min;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_min_o   = out_min_q;
  assign out_err_o   = out_err_q;

endmodule

### src/sparse_table_range_min_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                         Transaction
// s_axis    in         s_tvalid/s_tready/s_tdata/s_tuser  one command
// m_axis    out        m_tvalid/m_tready/m_tdata/m_tuser  one query result
// cfg       in         cfg_valid/cfg_ready/cfg_data       element_count write
//
// Loads write table level 0; queries read the table, then compare into the
// output register. A build has, per level whose span fits in element_count,
// a setup state, reads for start indices 0 to element_count - span and a
// drain state, then a final start state, paced by the RAM write port. Reset
// clears the control state and the built flag but not the table. A waiting
// result holds the next query at its compare and blocks the input.

module sparse_table_range_min_top #(
  parameter int DEPTH  = stmin_pkg::DEPTH_DEF,
  parameter int LEVELS = stmin_pkg::LEVELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // index [9:0], value [41:10], left [51:42], right [61:52], zero [63:62]
  input  logic [63:0]                   s_tdata,
  // cmd [1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // minimum [31:0]
  output logic [31:0]                   m_tdata,
  // error [0]
  output logic                          m_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stmin_pkg::CNT_W-1:0]   cfg_data_i
);

  stmin_pkg::stmin_cmd_t cmd;
  stmin_pkg::stmin_sts_t sts;
  logic signed [stmin_pkg::DATA_W-1:0] out_min;

  stmin_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_tvalid),
    .cmd_i       (s_tuser),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .s_ready_o   (s_tready),
    .cfg_ready_o (cfg_ready_o)
  );

  stmin_dp #(
    .DEPTH  (DEPTH),
    .LEVELS (LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .index_i     (s_tdata[9:0]),
    .value_i     (s_tdata[41:10]),
    .left_i      (s_tdata[51:42]),
    .right_i     (s_tdata[61:52]),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_tready),
    .out_valid_o (m_tvalid),
    .out_min_o   (out_min),
    .out_err_o   (m_tuser)
  );

  assign m_tdata = out_min;

endmodule
